@@ rtl/cell_voltage_frame_monitor_defines.svh @@
// Assertion macros shared by the monitor RTL.
`ifndef CELL_VOLTAGE_FRAME_MONITOR_DEFINES_SVH
`define CELL_VOLTAGE_FRAME_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CVFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cell monitor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CVFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cell monitor assertion failed");

`endif

@@ rtl/cvfm_pkg.sv @@
`default_nettype none

package cvfm_pkg;

    // Storage and field geometry.
    localparam int NUM_CELLS     = 96;
    localparam int FRACTION_BITS = 4;
    localparam int CELL_AW       = $clog2(NUM_CELLS);
    localparam int CNT_W         = $clog2(NUM_CELLS + 1);
    localparam int CELL_W        = 17;
    localparam int SUM_W         = 23;
    localparam int ID_W          = 29;
    localparam int RAW_W         = 12;
    localparam int MV_W          = 13;
    localparam int IDX_W         = 7;
    localparam int READINGS      = 4;

    // Frame window and voltage limits.
    localparam logic [ID_W-1:0]   ID_FIRST    = ID_W'(32'h1C0);
    localparam logic [ID_W-1:0]   ID_LAST     = ID_W'(32'h1DF);
    localparam int                OFFSET_INT  = 1000;
    localparam int                LIMIT_INT   = 4400;
    localparam int                NONE_INT    = 4500;
    localparam logic [MV_W-1:0]   OFFSET_MV   = MV_W'(OFFSET_INT);
    localparam logic [MV_W-1:0]   LIMIT_MV    = MV_W'(LIMIT_INT);
    localparam logic [CELL_W-1:0] THRESHOLD   = CELL_W'(OFFSET_INT << FRACTION_BITS);
    localparam logic [CELL_W-1:0] NONE_MIN    = CELL_W'(NONE_INT << FRACTION_BITS);
    localparam int                CELL_SHIFT  = 2;
    localparam int                MAXF_SHIFT  = 4;

    // Operation codes.
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_SUMMARY = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FRD  = 5'b00010,
        S_FWR  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // First-order filter step: old + floor((target - old) / 2^sh).
    function automatic logic [CELL_W-1:0] iir_step(
        input logic [CELL_W-1:0] old,
        input logic [CELL_W-1:0] target,
        input int unsigned       sh
    );
        logic signed [CELL_W:0] diff;
        logic signed [CELL_W:0] delta;
        diff  = $signed({1'b0, target}) - $signed({1'b0, old});
        delta = diff >>> sh;
        return old + delta[CELL_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/cell_voltage_frame_monitor.sv @@
// Cell voltage frame monitor.
// Input channel (i_in_valid / o_in_ready) carries either a monitor frame
// (i_operation = 0) or a summary request (i_operation = 1). Output channel
// (o_out_valid / i_out_ready) returns one result per summary request only.
// Cell voltages live in a 96-entry single-port RAM with a registered read.
// A frame in the cell window is applied as four read-modify-write passes
// (a read state then a write state each), holding the input throughout;
// an ignored frame is dropped without leaving idle. A summary reads one
// cell per cycle through the RAM port, and the input stays busy until its
// result is loaded into the output register.
// Reset clears per-cell valid flags at once, so every cell reads as zero,
// and clears the max filter; no clearing pass is needed.
// The result sits in an output register: frames keep being taken while it
// waits, and a later summary holds in its final state until the receiver
// takes the pending result.
`default_nettype none
`include "cell_voltage_frame_monitor_defines.svh"

module cell_voltage_frame_monitor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_operation,
    input  wire logic [cvfm_pkg::ID_W-1:0]   i_frame_id,
    input  wire logic [31:0]                 i_payload_low,
    input  wire logic [31:0]                 i_payload_high,
    input  wire logic                        i_balancer_hold,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [cvfm_pkg::CELL_W-1:0]      o_min_cell,
    output logic [cvfm_pkg::CELL_W-1:0]      o_max_cell,
    output logic [cvfm_pkg::SUM_W-1:0]       o_pack_total,
    output logic [cvfm_pkg::CELL_W-1:0]      o_smoothed_max
);
    import cvfm_pkg::*;

    t_state                    r_state, n_state;
    logic [CELL_W-1:0]         r_mem [NUM_CELLS];
    logic [NUM_CELLS-1:0]      r_vld;
    logic [CELL_W-1:0]         r_rd_data;
    logic                      r_rd_vld;
    logic [IDX_W-1:0]          r_idx;
    logic [READINGS*RAW_W-1:0] r_raws;
    logic [1:0]                r_step;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_sv;
    logic [CELL_W-1:0]         r_min, r_max, r_maxf;
    logic [SUM_W-1:0]          r_sum;
    logic                      r_out_valid;
    logic [CELL_W-1:0]         r_out_min, r_out_max, r_out_filt;
    logic [SUM_W-1:0]          r_out_sum;

    logic                      in_fire;
    logic                      frame_ok;
    logic [4:0]                frame_off;
    logic [4:0]                group;
    logic [IDX_W-1:0]          base;
    logic                      idx_ok;
    logic                      rd_en;
    logic [CELL_AW-1:0]        rd_addr;
    logic [RAW_W-1:0]          raw;
    logic [MV_W-1:0]           mv;
    logic [CELL_W-1:0]         v_new;
    logic [CELL_W-1:0]         old_val;
    logic                      wr_en;
    logic [CELL_W-1:0]         wr_data;
    logic [CELL_W-1:0]         scan_val;
    logic                      out_free;
    logic [CELL_W-1:0]         filt_new;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Frame decode: window, skipped slot and hold flag; group to cell index.
    assign frame_ok  = (i_frame_id >= ID_FIRST) && (i_frame_id <= ID_LAST) &&
                       (i_frame_id[1:0] != 2'b11) && !i_balancer_hold;
    assign frame_off = i_frame_id[4:0];
    assign group     = {1'b0, frame_off[4:2], 1'b0} + {2'b00, frame_off[4:2]}
                       + {3'b000, frame_off[1:0]};
    assign base      = {group, 2'b00};

    assign idx_ok = (r_idx < IDX_W'(NUM_CELLS));

    // RAM read port: one cell for a frame update or one per scan cycle.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            S_FRD: begin
                rd_en   = idx_ok;
                rd_addr = r_idx[CELL_AW-1:0];
            end
            S_SCAN: begin
                rd_en   = (r_cnt < CNT_W'(NUM_CELLS));
                rd_addr = r_cnt[CELL_AW-1:0];
            end
            default: begin
                rd_en   = 1'b0;
            end
        endcase
    end

    // Cell update: range check, direct load of an empty cell or a quarter step.
    assign raw     = r_raws[RAW_W-1:0];
    assign mv      = {1'b0, raw} + OFFSET_MV;
    assign v_new   = CELL_W'(mv) << FRACTION_BITS;
    assign old_val = r_rd_vld ? r_rd_data : '0;
    assign wr_en   = (r_state == S_FWR) && idx_ok && (mv <= LIMIT_MV);
    assign wr_data = (old_val == '0) ? v_new : iir_step(old_val, v_new, CELL_SHIFT);

    // Cell RAM and its read register.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx[CELL_AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Written flags: a cell never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_idx[CELL_AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_operation == OP_SUMMARY) begin
                        n_state = S_SCAN;
                    end else if (frame_ok) begin
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                n_state = (r_step == 2'(READINGS - 1)) ? S_IDLE : S_FRD;
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(NUM_CELLS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Frame and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
            r_sv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv    <= (r_state == S_SCAN) && rd_en;
            if (in_fire) begin
                r_step <= '0;
                r_cnt  <= '0;
            end
            if (r_state == S_FWR) begin
                r_step <= r_step + 2'd1;
            end
            if (r_state == S_SCAN && rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Frame payload: cell index and the four packed readings.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx  <= base;
            r_raws <= {i_payload_high[27:16], i_payload_high[15:4],
                       i_payload_high[3:0], i_payload_low[31:24],
                       i_payload_low[23:12]};
        end else if (r_state == S_FWR) begin
            r_idx  <= r_idx + IDX_W'(1);
            r_raws <= r_raws >> RAW_W;
        end
    end

    // Scan accumulators over cells above the validity threshold.
    assign scan_val = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_min <= NONE_MIN;
            r_max <= '0;
            r_sum <= '0;
        end else if (r_sv && (scan_val > THRESHOLD)) begin
            r_sum <= r_sum + SUM_W'(scan_val);
            if (scan_val < r_min) begin
                r_min <= scan_val;
            end
            if (scan_val > r_max) begin
                r_max <= scan_val;
            end
        end
    end

    // Max filter: load on first use, else a 1/16 step.
    assign filt_new = (r_maxf == '0) ? r_max : iir_step(r_maxf, r_max, MAXF_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxf      <= '0;
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_maxf      <= filt_new;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_min  <= r_min;
            r_out_max  <= r_max;
            r_out_sum  <= r_sum;
            r_out_filt <= filt_new;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_min_cell     = r_out_min;
    assign o_max_cell     = r_out_max;
    assign o_pack_total   = r_out_sum;
    assign o_smoothed_max = r_out_filt;

    // Checks on the sequencer.
    `CVFM_ASSERT_NEXT(a_read_then_write, i_clk, i_rst_n, r_state == S_FRD, r_state == S_FWR)
    `CVFM_ASSERT_NEXT(a_summary_starts_scan, i_clk, i_rst_n,
        in_fire && (i_operation == OP_SUMMARY), (r_state == S_SCAN) && (r_cnt == '0))
    `CVFM_ASSERT_NOW(a_sample_in_scan, i_clk, i_rst_n, r_sv, r_state == S_SCAN)
    `CVFM_ASSERT_NEXT(a_result_not_overwritten, i_clk, i_rst_n,
        (r_state == S_DONE) && r_out_valid && !i_out_ready, r_state == S_DONE)

endmodule

`default_nettype wire
